// ----- hdl/bounded_fifo_server_admission_assert.svh -----
// Assertion macros used by the checker file of the admission block.
`ifndef BOUNDED_FIFO_SERVER_ADMISSION_ASSERT_SVH
`define BOUNDED_FIFO_SERVER_ADMISSION_ASSERT_SVH

// Implication in the same cycle, ignored while reset is held.
`define BFSA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle, ignored while reset is held.
`define BFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Implication in the same cycle, checked during reset too.
`define BFSA_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hdl/bfsa_pkg.sv -----
// Package with widths, reset values and register decode of the admission block.
`default_nettype none
package bfsa_pkg;
  localparam int LIMIT_W = 10;
  localparam int TIME_W  = 40;
  localparam int DUR_W   = 32;
  localparam int FIN_W   = 48;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  localparam int QUEUE_DEPTH_DEF = 1024;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd1023;

  // Word index of each configuration register (paddr bit above the byte offset)
  localparam logic REG_QUEUE_LIMIT = 1'b0;

  localparam logic [FIN_W-1:0] FIN_MAX = {FIN_W{1'b1}};
endpackage
`default_nettype wire

// ----- hdl/bounded_fifo_server_admission.sv -----
// Single-server admission with a bounded ring of planned finish times.
//
// Input channel: arrival_time_i, duration_i under in_valid_i / in_stall_o.
// Output channel: accepted_o, finish_time_o under out_valid_o / out_stall_i.
// One result transaction comes out for every input transaction, in order.
// Configuration: APB-style port, register queue_limit at byte address 0.
//
// Steps: a taken request retires R ring entries in ST_RETIRE, R being those
// finished by its arrival time, then loads its result in ST_FINISH. Retiring
// walks the ring one entry per cycle through the single registered read port
// of the finish ring; no new request enters until both steps are done, and R
// averages at most one per admitted job. in_stall_o is high while a request
// is in progress. The output register lets the next request enter while a
// result waits. If the receiver stalls, the finished request holds in its
// last step until the pending result is taken, then loads its own result.
// Reset empties the ring (pointers and count cleared), sets queue_limit to
// 1023 and drops any pending result. No clearing pass over the ring memory.
`default_nettype none
module bounded_fifo_server_admission #(
  parameter int QUEUE_DEPTH = bfsa_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input transactions
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [bfsa_pkg::TIME_W-1:0]   arrival_time_i,
  input  wire logic [bfsa_pkg::DUR_W-1:0]    duration_i,
  // result transactions
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               accepted_o,
  output logic [bfsa_pkg::FIN_W-1:0]         finish_time_o,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bfsa_pkg::APB_AW-1:0]   paddr,
  input  wire logic [bfsa_pkg::APB_DW-1:0]   pwdata,
  output logic [bfsa_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > bfsa_pkg::LIMIT_W) ? CNT_W : bfsa_pkg::LIMIT_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RETIRE,
    ST_FINISH
  } state_e;

  state_e                         state_q;
  logic [PTR_W-1:0]               head_q, head_d;
  logic [PTR_W-1:0]               tail_q;
  logic [CNT_W-1:0]               count_q;
  logic [bfsa_pkg::LIMIT_W-1:0]   limit_q;
  logic [bfsa_pkg::TIME_W-1:0]    time_q;
  logic [bfsa_pkg::DUR_W-1:0]     dur_q;
  logic [bfsa_pkg::FIN_W-1:0]     last_fin_q;
  logic                           out_valid_q;
  logic                           accepted_q;
  logic [bfsa_pkg::FIN_W-1:0]     finish_q;

  logic [bfsa_pkg::FIN_W-1:0]     ring_mem [QUEUE_DEPTH];
  logic [bfsa_pkg::FIN_W-1:0]     head_fin_q;

  logic                           in_take;
  logic                           out_take;
  logic                           pop;
  logic                           finish_go;
  logic                           admit;
  logic [bfsa_pkg::FIN_W-1:0]     base;
  logic [bfsa_pkg::FIN_W:0]       sum;
  logic [bfsa_pkg::FIN_W-1:0]     fin;
  logic                           cfg_wr;

  // Handshakes
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  // Retire the head entry while it is live and finished by the arrival time
  assign pop = (state_q == ST_RETIRE) && (count_q != '0) &&
               (head_fin_q <= {{(bfsa_pkg::FIN_W-bfsa_pkg::TIME_W){1'b0}}, time_q});

  // Admission decision and saturating finish time
  assign admit = (CMP_W'(count_q) <= CMP_W'(limit_q)) && (count_q != CNT_FULL);
  assign base  = (count_q == '0) ?
                 {{(bfsa_pkg::FIN_W-bfsa_pkg::TIME_W){1'b0}}, time_q} : last_fin_q;
  assign sum   = {1'b0, base} + {{(bfsa_pkg::FIN_W+1-bfsa_pkg::DUR_W){1'b0}}, dur_q};
  assign fin   = sum[bfsa_pkg::FIN_W] ? bfsa_pkg::FIN_MAX : sum[bfsa_pkg::FIN_W-1:0];

  // Finish only once the output register is free or being emptied
  assign finish_go = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  // Next head pointer feeds the ring read address
  always_comb begin
    head_d = head_q;
    if (pop) begin
      head_d = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
    end
  end

  // Finish ring: one write port, one registered read port at the next head
  always_ff @(posedge clk_i) begin
    if (finish_go && admit) begin
      ring_mem[tail_q] <= fin;
    end
    head_fin_q <= ring_mem[head_d];
  end

  // Sequencer, ring pointers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      time_q      <= '0;
      dur_q       <= '0;
      last_fin_q  <= '0;
      out_valid_q <= 1'b0;
      accepted_q  <= 1'b0;
      finish_q    <= '0;
    end else begin
      head_q <= head_d;
      if (out_take) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_take) begin
            time_q  <= arrival_time_i;
            dur_q   <= duration_i;
            state_q <= ST_RETIRE;
          end
        end
        ST_RETIRE: begin
          if (pop) begin
            count_q <= count_q - CNT_W'(1);
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (finish_go) begin
            out_valid_q <= 1'b1;
            accepted_q  <= admit;
            finish_q    <= admit ? fin : '0;
            if (admit) begin
              last_fin_q <= fin;
              tail_q     <= (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
              count_q    <= count_q + CNT_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Configuration register
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[bfsa_pkg::APB_AW-1] == bfsa_pkg::REG_QUEUE_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= bfsa_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_q <= pwdata[bfsa_pkg::LIMIT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[bfsa_pkg::APB_AW-1] == bfsa_pkg::REG_QUEUE_LIMIT) ?
                  {{(bfsa_pkg::APB_DW-bfsa_pkg::LIMIT_W){1'b0}}, limit_q} : '0;

  // Outputs
  assign out_valid_o   = out_valid_q;
  assign accepted_o    = accepted_q;
  assign finish_time_o = finish_q;
endmodule
`default_nettype wire

// ----- hdl/bfsa_checker.sv -----
// Port-level checker for the admission block, bound to the top level.
`default_nettype none
`include "bounded_fifo_server_admission_assert.svh"
module bfsa_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic                        accepted_o,
  input wire logic [bfsa_pkg::FIN_W-1:0]  finish_time_o
);
  // Stalled result holds its value
  `BFSA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(accepted_o) && $stable(finish_time_o), "result changed while stalled")

  // Rejected job reports a zero finish time
  `BFSA_ASSERT_SAME(a_reject_zero, out_valid_o && !accepted_o, finish_time_o == '0, "rejected result with nonzero finish time")

  // Block is busy right after it takes a request
  `BFSA_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o && !(out_valid_o && !$past(out_valid_o)), "request taken without busy period")

  // Reset drops any pending result
  `BFSA_ASSERT_ALWAYS(a_reset_clear, !rst_ni, !out_valid_o, "result valid during reset")
endmodule

bind bounded_fifo_server_admission bfsa_checker u_bfsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .accepted_o    (accepted_o),
  .finish_time_o (finish_time_o)
);
`default_nettype wire
